// ===== hw/rtl/set_get_command_stream_parser_assert.svh =====
// Assertion macros for the set/get command stream parser RTL.
// Self-contained; taken in by `include where a module checks its own logic.
`ifndef SET_GET_COMMAND_STREAM_PARSER_ASSERT_SVH
`define SET_GET_COMMAND_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SGCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sgcp assertion failed");

// Next-cycle implication, checked outside reset.
`define SGCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sgcp assertion failed");

`endif

// ===== hw/rtl/sgcp_pkg.sv =====
// Package for the set/get command stream parser: phase and event codes,
// character constants, the event word type and parameter defaults. No dependencies.
package sgcp_pkg;

    localparam int LEN_WIDTH_DEF = 16;
    localparam int INT_WIDTH_DEF = 32;
    localparam int INT_OUT_WIDTH = 32;
    localparam int DEC_BASE      = 10;

    localparam logic [7:0] CH_SET   = 8'h73; // 's'
    localparam logic [7:0] CH_GET   = 8'h67; // 'g'
    localparam logic [7:0] CH_INT   = 8'h69; // 'i'
    localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CH_NINE  = 8'h39; // '9'

    typedef enum logic [2:0] {
        PH_CMD       = 3'd0,
        PH_KEYLEN    = 3'd1,
        PH_KEYBYTES  = 3'd2,
        PH_VALSTART  = 3'd3,
        PH_INTDIGITS = 3'd4,
        PH_STRLEN    = 3'd5,
        PH_STRBYTES  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        EV_SET      = 3'd0,
        EV_GET      = 3'd1,
        EV_INVALID  = 3'd2,
        EV_KEYBYTE  = 3'd3,
        EV_EMPTYKEY = 3'd4,
        EV_INT      = 3'd5,
        EV_STRBYTE  = 3'd6,
        EV_EMPTYSTR = 3'd7
    } t_event_kind;

    typedef struct packed {
        t_event_kind                kind;
        logic                       is_set_key;
        logic [7:0]                 data_byte;
        logic [INT_OUT_WIDTH-1:0]   int_value;
        logic                       last_byte;
    } t_event;

    // Word passed from the input register to the parser core.
    typedef struct packed {
        logic valid;
        logic mode;
        logic [7:0] byte_value;
    } t_in_word;

endpackage

// ===== hw/rtl/sgcp_in_reg.sv =====
// Input register of the set/get command stream parser.
// Captures one stream word; depends on sgcp_pkg.
module sgcp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [7:0]        i_byte,
    input  logic              i_drain,
    output sgcp_pkg::t_in_word o_word
);

    logic       r_valid;
    logic       r_mode;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode <= i_mode;
            r_byte <= i_byte;
        end
    end

    assign o_word = '{valid: r_valid, mode: r_mode, byte_value: r_byte};

endmodule

// ===== hw/rtl/sgcp_parse_core.sv =====
// Parser core: phase register, length counter and integer accumulator,
// with the per-word next state and event logic. Depends on sgcp_pkg and the assert header.
`include "set_get_command_stream_parser_assert.svh"

module sgcp_parse_core #(
    parameter int LEN_WIDTH = sgcp_pkg::LEN_WIDTH_DEF,
    parameter int INT_WIDTH = sgcp_pkg::INT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  sgcp_pkg::t_in_word i_word,
    output logic               o_ev_valid,
    output sgcp_pkg::t_event   o_event
);

    sgcp_pkg::t_phase       r_phase, n_phase;
    logic [LEN_WIDTH-1:0]   r_len, n_len;
    logic [INT_WIDTH-1:0]   r_acc, n_acc;
    logic                   r_set, n_set;

    logic                   w_digit;
    logic [3:0]             w_dval;
    logic [LEN_WIDTH+3:0]   w_len_ext;
    logic [INT_WIDTH+3:0]   w_acc_ext;
    logic [LEN_WIDTH-1:0]   w_len_sat;
    logic [INT_WIDTH-1:0]   w_acc_sat;
    logic                   w_len_last;
    logic                   w_len_zero;
    logic [63:0]            w_acc64;

    always_comb begin
        w_digit = i_word.byte_value inside {[sgcp_pkg::CH_ZERO:sgcp_pkg::CH_NINE]};
    end
    assign w_dval = i_word.byte_value[3:0];

    // acc*10+d overflows exactly when it needs bits above the field width
    assign w_len_ext = (LEN_WIDTH+4)'(r_len) * (LEN_WIDTH+4)'(sgcp_pkg::DEC_BASE)
                     + (LEN_WIDTH+4)'(w_dval);
    assign w_acc_ext = (INT_WIDTH+4)'(r_acc) * (INT_WIDTH+4)'(sgcp_pkg::DEC_BASE)
                     + (INT_WIDTH+4)'(w_dval);
    assign w_len_sat = (|w_len_ext[LEN_WIDTH+3:LEN_WIDTH]) ? '1 : w_len_ext[LEN_WIDTH-1:0];
    assign w_acc_sat = (|w_acc_ext[INT_WIDTH+3:INT_WIDTH]) ? '1 : w_acc_ext[INT_WIDTH-1:0];
    assign w_len_last = (r_len[LEN_WIDTH-1:1] == '0);
    assign w_len_zero = (r_len == '0);
    assign w_acc64    = 64'(r_acc);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_acc   = r_acc;
        n_set   = r_set;
        if (i_word.mode) begin
            n_phase = sgcp_pkg::PH_CMD;
            n_len   = '0;
            n_acc   = '0;
        end else begin
            case (r_phase)
                sgcp_pkg::PH_KEYLEN: begin
                    if (w_digit) begin
                        n_len = w_len_sat;
                    end else if (w_len_zero) begin
                        n_phase = r_set ? sgcp_pkg::PH_VALSTART : sgcp_pkg::PH_CMD;
                    end else begin
                        n_phase = sgcp_pkg::PH_KEYBYTES;
                    end
                end
                sgcp_pkg::PH_KEYBYTES: begin
                    n_len = w_len_last ? '0 : r_len - LEN_WIDTH'(1);
                    if (w_len_last) begin
                        n_phase = r_set ? sgcp_pkg::PH_VALSTART : sgcp_pkg::PH_CMD;
                    end
                end
                sgcp_pkg::PH_VALSTART: begin
                    if (i_word.byte_value == sgcp_pkg::CH_INT) begin
                        n_acc   = '0;
                        n_phase = sgcp_pkg::PH_INTDIGITS;
                    end else if (w_digit) begin
                        n_len   = LEN_WIDTH'(w_dval);
                        n_phase = sgcp_pkg::PH_STRLEN;
                    end else begin
                        n_len   = '0;
                        n_phase = sgcp_pkg::PH_CMD;
                    end
                end
                sgcp_pkg::PH_INTDIGITS: begin
                    if (w_digit) begin
                        n_acc = w_acc_sat;
                    end else begin
                        n_phase = sgcp_pkg::PH_CMD;
                    end
                end
                sgcp_pkg::PH_STRLEN: begin
                    if (w_digit) begin
                        n_len = w_len_sat;
                    end else if (w_len_zero) begin
                        n_phase = sgcp_pkg::PH_CMD;
                    end else begin
                        n_phase = sgcp_pkg::PH_STRBYTES;
                    end
                end
                sgcp_pkg::PH_STRBYTES: begin
                    n_len = w_len_last ? '0 : r_len - LEN_WIDTH'(1);
                    if (w_len_last) begin
                        n_phase = sgcp_pkg::PH_CMD;
                    end
                end
                default: begin
                    n_phase = sgcp_pkg::PH_CMD;
                    if (i_word.byte_value == sgcp_pkg::CH_SET) begin
                        n_set   = 1'b1;
                        n_len   = '0;
                        n_phase = sgcp_pkg::PH_KEYLEN;
                    end else if (i_word.byte_value == sgcp_pkg::CH_GET) begin
                        n_set   = 1'b0;
                        n_len   = '0;
                        n_phase = sgcp_pkg::PH_KEYLEN;
                    end
                end
            endcase
        end
    end

    // Event output
    always_comb begin
        o_ev_valid = 1'b0;
        o_event    = '0;
        if (!i_word.mode) begin
            case (r_phase)
                sgcp_pkg::PH_KEYLEN: begin
                    if (!w_digit && w_len_zero) begin
                        o_ev_valid         = 1'b1;
                        o_event.kind       = sgcp_pkg::EV_EMPTYKEY;
                        o_event.is_set_key = r_set;
                    end
                end
                sgcp_pkg::PH_KEYBYTES: begin
                    o_ev_valid         = 1'b1;
                    o_event.kind       = sgcp_pkg::EV_KEYBYTE;
                    o_event.is_set_key = r_set;
                    o_event.data_byte  = i_word.byte_value;
                    o_event.last_byte  = w_len_last;
                end
                sgcp_pkg::PH_VALSTART: begin
                    if (i_word.byte_value != sgcp_pkg::CH_INT && !w_digit) begin
                        o_ev_valid   = 1'b1;
                        o_event.kind = sgcp_pkg::EV_EMPTYSTR;
                    end
                end
                sgcp_pkg::PH_INTDIGITS: begin
                    if (!w_digit) begin
                        o_ev_valid        = 1'b1;
                        o_event.kind      = sgcp_pkg::EV_INT;
                        o_event.int_value = w_acc64[sgcp_pkg::INT_OUT_WIDTH-1:0];
                    end
                end
                sgcp_pkg::PH_STRLEN: begin
                    if (!w_digit && w_len_zero) begin
                        o_ev_valid   = 1'b1;
                        o_event.kind = sgcp_pkg::EV_EMPTYSTR;
                    end
                end
                sgcp_pkg::PH_STRBYTES: begin
                    o_ev_valid        = 1'b1;
                    o_event.kind      = sgcp_pkg::EV_STRBYTE;
                    o_event.data_byte = i_word.byte_value;
                    o_event.last_byte = w_len_last;
                end
                default: begin
                    o_ev_valid = 1'b1;
                    if (i_word.byte_value == sgcp_pkg::CH_SET) begin
                        o_event.kind = sgcp_pkg::EV_SET;
                    end else if (i_word.byte_value == sgcp_pkg::CH_GET) begin
                        o_event.kind = sgcp_pkg::EV_GET;
                    end else begin
                        o_event.kind = sgcp_pkg::EV_INVALID;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sgcp_pkg::PH_CMD;
            r_len   <= '0;
            r_acc   <= '0;
            r_set   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_set   <= n_set;
        end
    end

    `SGCP_ASSERT_NOW(a_keybyte_phase, i_clk, i_rst_n,
        o_ev_valid && o_event.kind == sgcp_pkg::EV_KEYBYTE, r_phase == sgcp_pkg::PH_KEYBYTES)
    `SGCP_ASSERT_NEXT(a_abort_clears, i_clk, i_rst_n, i_fire && i_word.mode,
        r_phase == sgcp_pkg::PH_CMD && r_len == '0 && r_acc == '0)
    `SGCP_ASSERT_NOW(a_keybytes_nonzero, i_clk, i_rst_n,
        r_phase == sgcp_pkg::PH_KEYBYTES, r_len != '0)
    `SGCP_ASSERT_NOW(a_strbytes_nonzero, i_clk, i_rst_n,
        r_phase == sgcp_pkg::PH_STRBYTES, r_len != '0)

endmodule

// ===== hw/rtl/sgcp_out_reg.sv =====
// Output register of the set/get command stream parser.
// Holds one event word until the receiver takes it; depends on sgcp_pkg.
module sgcp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_ev_valid,
    input  sgcp_pkg::t_event i_event,
    input  logic             i_ready,
    output logic             o_can_load,
    output logic             o_valid,
    output sgcp_pkg::t_event o_event
);

    logic             r_valid;
    sgcp_pkg::t_event r_event;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load && i_ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load && i_ev_valid) begin
            r_event <= i_event;
        end
    end

    assign o_valid = r_valid;
    assign o_event = r_event;

endmodule

// ===== hw/rtl/set_get_command_stream_parser.sv =====
// Set/get command stream parser, top level.
// Byte stream in on s_axis_*, one word per byte; events out on m_axis_*.
// s_axis_tdata carries the stream byte, s_axis_tuser the abort flag (1 = abort,
// return to command state, no event). Each byte yields zero or one event.
// m_axis_tuser carries the event kind and the set/get key flag, m_axis_tdata
// the key or string byte and the saturated integer, m_axis_tlast the final
// byte of a key or string run.
// An accepted byte is registered in the input register; its event is then loaded
// into the output register, which drives m_axis_tvalid, unless that register still
// holds an event not yet taken. Throughput is one byte per cycle while the receiver
// takes events, set by the phase update in the parser core.
// A stalled receiver holds the event in the output register; one more byte
// waits in the input register, then s_axis_tready drops until the event is
// taken. Reset (synchronous, active low) empties both registers and returns
// the parser to the awaiting-command state with length and integer cleared.
// Depends on sgcp_pkg, sgcp_in_reg, sgcp_parse_core and sgcp_out_reg.
module set_get_command_stream_parser #(
    parameter int LEN_WIDTH = sgcp_pkg::LEN_WIDTH_DEF,
    parameter int INT_WIDTH = sgcp_pkg::INT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
    input  logic        s_axis_tuser,  // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [7:0] data_byte, [39:8] int_value
    output logic [3:0]  m_axis_tuser,  // [2:0] event_kind, [3] is_set_key
    output logic        m_axis_tlast   // last_byte
);

    sgcp_pkg::t_in_word w_word;
    sgcp_pkg::t_event   w_ev, w_out_ev;
    logic               w_ev_valid;
    logic               w_can_load;
    logic               w_fire;

    assign w_fire = w_word.valid && w_can_load;

    sgcp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (s_axis_tuser),
        .i_byte  (s_axis_tdata),
        .i_drain (w_can_load),
        .o_word  (w_word)
    );

    sgcp_parse_core #(
        .LEN_WIDTH (LEN_WIDTH),
        .INT_WIDTH (INT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_word     (w_word),
        .o_ev_valid (w_ev_valid),
        .o_event    (w_ev)
    );

    sgcp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_ev_valid (w_ev_valid),
        .i_event    (w_ev),
        .i_ready    (m_axis_tready),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .o_event    (w_out_ev)
    );

    assign m_axis_tdata = {w_out_ev.int_value, w_out_ev.data_byte};
    assign m_axis_tuser = {w_out_ev.is_set_key, w_out_ev.kind};
    assign m_axis_tlast = w_out_ev.last_byte;

endmodule

// ===== test/sgcp_event_check.sv =====
// Event checker for the set/get command stream parser: tracks accepted input words,
// predicts the event each one causes and compares the events leaving the block.
// Depends on sgcp_pkg for phase and event codes, character constants and t_event.
module sgcp_event_check #(
    parameter int LEN_WIDTH = sgcp_pkg::LEN_WIDTH_DEF,
    parameter int INT_WIDTH = sgcp_pkg::INT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_abort,
    input  logic        i_ev_valid,
    input  logic        i_ev_ready,
    input  logic [39:0] i_ev_data,   // [7:0] data_byte, [39:8] int_value
    input  logic [3:0]  i_ev_user,   // [2:0] event_kind, [3] is_set_key
    input  logic        i_ev_last,
    output int          o_pending,
    output int          o_errors
);
    import sgcp_pkg::*;

    localparam int MAX_REPORTS = 10;

    t_phase               stage;
    logic [LEN_WIDTH-1:0] count_left;
    logic [INT_WIDTH-1:0] int_sum;
    logic                 set_mode;
    t_event               pending_events[$];
    int                   event_errors = 0;

    // acc * 10 + digit, stuck at the all-ones value of the given width
    function automatic logic [63:0] decimal_shift_in(input logic [63:0] acc,
                                                     input logic [3:0] digit,
                                                     input int width);
        logic [63:0] ceiling;
        logic [67:0] wide;
        ceiling = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
        wide = 68'(acc) * 68'(DEC_BASE) + 68'(digit);
        return (wide > 68'(ceiling)) ? ceiling : wide[63:0];
    endfunction

    // Advance the parse by one word; returns 1 when the word yields an event.
    function automatic bit parse_word(input logic abort, input logic [7:0] b,
                                      output t_event ev);
        logic       is_digit;
        logic [3:0] digit;
        logic       fin;
        ev = '0;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        digit = 4'(b - CH_ZERO);
        if (abort) begin
            stage = PH_CMD;
            count_left = '0;
            int_sum = '0;
            return 1'b0;
        end
        case (stage)
            PH_KEYLEN, PH_STRLEN: begin
                if (is_digit) begin
                    count_left = LEN_WIDTH'(decimal_shift_in(64'(count_left), digit,
                                                             LEN_WIDTH));
                    return 1'b0;
                end
                if (count_left != '0) begin
                    stage = (stage == PH_KEYLEN) ? PH_KEYBYTES : PH_STRBYTES;
                    return 1'b0;
                end
                if (stage == PH_KEYLEN) begin
                    stage = set_mode ? PH_VALSTART : PH_CMD;
                    ev.kind = EV_EMPTYKEY;
                    ev.is_set_key = set_mode;
                end else begin
                    stage = PH_CMD;
                    ev.kind = EV_EMPTYSTR;
                end
                return 1'b1;
            end
            PH_KEYBYTES, PH_STRBYTES: begin
                fin = (count_left <= 1);
                count_left = fin ? '0 : count_left - 1'b1;
                if (stage == PH_KEYBYTES) begin
                    ev.kind = EV_KEYBYTE;
                    ev.is_set_key = set_mode;
                    if (fin) stage = set_mode ? PH_VALSTART : PH_CMD;
                end else begin
                    ev.kind = EV_STRBYTE;
                    if (fin) stage = PH_CMD;
                end
                ev.data_byte = b;
                ev.last_byte = fin;
                return 1'b1;
            end
            PH_VALSTART: begin
                if (b == CH_INT) begin
                    int_sum = '0;
                    stage = PH_INTDIGITS;
                    return 1'b0;
                end
                if (is_digit) begin
                    count_left = LEN_WIDTH'(digit);
                    stage = PH_STRLEN;
                    return 1'b0;
                end
                count_left = '0;
                stage = PH_CMD;
                ev.kind = EV_EMPTYSTR;
                return 1'b1;
            end
            PH_INTDIGITS: begin
                if (is_digit) begin
                    int_sum = INT_WIDTH'(decimal_shift_in(64'(int_sum), digit, INT_WIDTH));
                    return 1'b0;
                end
                stage = PH_CMD;
                ev.kind = EV_INT;
                ev.int_value = INT_OUT_WIDTH'(int_sum);
                return 1'b1;
            end
            default: begin
                stage = PH_CMD;
                if (b == CH_SET || b == CH_GET) begin
                    set_mode = (b == CH_SET);
                    count_left = '0;
                    stage = PH_KEYLEN;
                    ev.kind = set_mode ? EV_SET : EV_GET;
                end else begin
                    ev.kind = EV_INVALID;
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic string fmt_event(input t_event e);
        return $sformatf("kind=%s set=%0b byte=%02h int=%0d last=%0b",
                         e.kind.name(), e.is_set_key, e.data_byte, e.int_value, e.last_byte);
    endfunction

    always @(posedge i_clk) begin : track
        t_event got;
        t_event want;
        t_event fresh;
        if (!i_rst_n) begin
            stage = PH_CMD;
            count_left = '0;
            int_sum = '0;
            set_mode = 1'b0;
            pending_events.delete();
        end else begin
            // retire first: an event can never belong to a word taken in the same cycle
            if (i_ev_valid && i_ev_ready) begin
                got.kind = t_event_kind'(i_ev_user[2:0]);
                got.is_set_key = i_ev_user[3];
                got.data_byte = i_ev_data[7:0];
                got.int_value = i_ev_data[39:8];
                got.last_byte = i_ev_last;
                if (pending_events.size() == 0) begin
                    event_errors++;
                    if (event_errors <= MAX_REPORTS)
                        $display("event with nothing pending: %s", fmt_event(got));
                end else begin
                    want = pending_events.pop_front();
                    if (got !== want) begin
                        event_errors++;
                        if (event_errors <= MAX_REPORTS)
                            $display("event mismatch: expected %s, got %s",
                                     fmt_event(want), fmt_event(got));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_word(i_in_abort, i_in_byte, fresh))
                    pending_events.push_back(fresh);
            end
        end
        o_pending <= pending_events.size();
        o_errors <= event_errors;
    end

endmodule

// ===== test/tb.sv =====
// Top of the set/get command stream parser testbench: clock, reset, byte stimulus and
// receiver stalls, with the verdict. Depends on sgcp_pkg, the parser and sgcp_event_check.
module tb;
    import sgcp_pkg::*;

    localparam logic MODE_DATA        = 1'b0;
    localparam logic MODE_ABORT       = 1'b1;
    localparam int   HOLD_CYCLES      = 400;
    localparam int   STALL_LIMIT      = 3000;
    localparam int   RANDOM_PHASES    = 5;
    localparam int   PHASE_WORDS      = 200;
    localparam int   KEY_PREFIX_BYTES = 24;

    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_THIRD  = 2;
    localparam int RX_MOSTLY = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] byte_value
    logic        s_axis_tuser;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [7:0] data_byte, [39:8] int_value
    logic [3:0]  m_axis_tuser;   // [2:0] event_kind, [3] is_set_key
    logic        m_axis_tlast;

    int   pending_n;
    int   error_n;
    logic s_took = 1'b0;
    int   quiet_cycles = 0;
    int   rx_style = RX_COIN;
    bit   hold_rx = 1'b0;
    bit   use_gaps = 1'b1;
    int   burst_left = 0;
    int   sent_count = 0;

    set_get_command_stream_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    sgcp_event_check chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_in_ready(s_axis_tready),
        .i_in_byte (s_axis_tdata),
        .i_in_abort(s_axis_tuser),
        .i_ev_valid(m_axis_tvalid),
        .i_ev_ready(m_axis_tready),
        .i_ev_data (m_axis_tdata),
        .i_ev_user (m_axis_tuser),
        .i_ev_last (m_axis_tlast),
        .o_pending (pending_n),
        .o_errors  (error_n)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) s_took <= s_axis_tvalid && s_axis_tready;

    // end the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : rx
        int tick;
        tick = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rx = 1'b0;
            end else begin
                tick++;
                case (rx_style)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_THIRD:  m_axis_tready <= (tick % 3 == 0);
                    default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one word and hold it until taken; called at a falling edge.
    task automatic send_word(input logic mode, input logic [7:0] b);
        int gap;
        if (use_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= b;
        @(negedge i_clk);
        while (!s_took) @(negedge i_clk);
        sent_count++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_n != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_non_digit(input bit no_int_mark);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || (no_int_mark && b == CH_INT));
        return b;
    endfunction

    // Length digits with optional leading zeros; a zero length may have no digits.
    task automatic send_len(input int n, input bit bare_ok);
        int zeros;
        if (bare_ok && n == 0 && $urandom_range(0, 3) == 0) return;
        zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        repeat (zeros) send_word(MODE_DATA, CH_ZERO);
        if (n >= 10) send_word(MODE_DATA, CH_ZERO + 8'(n / 10));
        send_word(MODE_DATA, CH_ZERO + 8'(n % 10));
    endtask

    task automatic send_command();
        bit    set_cmd;
        int    klen;
        int    vlen;
        int    pick;
        string num;
        set_cmd = 1'($urandom_range(0, 1));
        send_word(MODE_DATA, set_cmd ? CH_SET : CH_GET);
        klen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        send_len(klen, 1'b1);
        send_word(MODE_DATA, pick_non_digit(1'b0));
        repeat (klen) send_word(MODE_DATA, 8'($urandom_range(0, 255)));
        if (!set_cmd) return;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            // drop the command right where the value would start
            send_word(MODE_ABORT, 8'($urandom_range(0, 255)));
        end else if (pick < 9) begin
            send_word(MODE_DATA, CH_INT);
            case ($urandom_range(0, 9))
                0: num = "4294967295";
                1: num = "4294967296";
                2: num = "999999999999";
                default: begin
                    num = "";
                    repeat ($urandom_range(0, 10))
                        num = {num, $sformatf("%0d", $urandom_range(0, 9))};
                end
            endcase
            foreach (num[k]) send_word(MODE_DATA, num[k]);
            send_word(MODE_DATA, pick_non_digit(1'b0));
        end else if (pick < 18) begin
            vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
            send_len(vlen, 1'b0);
            send_word(MODE_DATA, pick_non_digit(1'b0));
            repeat (vlen) send_word(MODE_DATA, 8'($urandom_range(0, 255)));
        end else begin
            send_word(MODE_DATA, pick_non_digit(1'b1));
        end
    endtask

    initial begin : stim
        int target;
        int r;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = MODE_DATA;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unknown command bytes, then an abort while idle
        send_word(MODE_DATA, 8'h00);
        send_word(MODE_DATA, 8'hFF);
        send_word(MODE_ABORT, 8'h5A);
        // get with an explicit zero length: empty key ('/' sits just below '0')
        send_word(MODE_DATA, CH_GET);
        send_word(MODE_DATA, CH_ZERO);
        send_word(MODE_DATA, 8'h2F);
        // set with no length digits (':' just above '9'), integer with no digits
        send_word(MODE_DATA, CH_SET);
        send_word(MODE_DATA, 8'h3A);
        send_word(MODE_DATA, CH_INT);
        send_word(MODE_DATA, 8'h20);
        // set, one-byte key and one-byte string
        send_word(MODE_DATA, CH_SET);
        send_word(MODE_DATA, CH_ZERO + 8'd1);
        send_word(MODE_DATA, 8'h3B);
        send_word(MODE_DATA, 8'hFF);
        send_word(MODE_DATA, CH_ZERO + 8'd1);
        send_word(MODE_DATA, 8'hFF);
        send_word(MODE_DATA, 8'h00);
        // value opening with a plain non-digit: empty string
        send_word(MODE_DATA, CH_SET);
        send_word(MODE_DATA, 8'h3A);
        send_word(MODE_DATA, 8'h7A);
        // zero-length string
        send_word(MODE_DATA, CH_SET);
        send_word(MODE_DATA, 8'h3A);
        send_word(MODE_DATA, CH_ZERO);
        send_word(MODE_DATA, 8'h3A);
        // abort in the middle of a key length
        send_word(MODE_DATA, CH_GET);
        send_word(MODE_DATA, CH_NINE);
        send_word(MODE_ABORT, 8'hA5);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            rx_style = ph % 4;
            use_gaps = (ph != 2);
            if (ph == 1) hold_rx = 1'b1;
            if (ph == 3) begin
                // key length saturates; send the start of the key back to back, then abort
                use_gaps = 1'b0;
                send_word(MODE_DATA, CH_GET);
                repeat (5) send_word(MODE_DATA, CH_NINE);
                send_word(MODE_DATA, pick_non_digit(1'b0));
                repeat (KEY_PREFIX_BYTES) send_word(MODE_DATA, 8'($urandom_range(0, 255)));
                send_word(MODE_ABORT, 8'($urandom_range(0, 255)));
                use_gaps = 1'b1;
            end
            target = sent_count + PHASE_WORDS;
            while (sent_count < target) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_command();
                end else if (r < 80) begin
                    send_word(MODE_DATA, 8'($urandom_range(0, 255)));
                end else if (r < 93) begin
                    send_word(MODE_DATA, $urandom_range(0, 1) ? CH_SET : CH_GET);
                    repeat ($urandom_range(0, 5))
                        send_word(MODE_DATA, $urandom_range(0, 1) ?
                                  CH_ZERO + 8'($urandom_range(0, 9)) :
                                  8'($urandom_range(0, 255)));
                    send_word(MODE_ABORT, 8'($urandom_range(0, 255)));
                end else begin
                    send_word(MODE_ABORT, 8'($urandom_range(0, 255)));
                end
            end
            drain();
        end

        if (error_n == 0 && pending_n == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sgcp_pkg.sv
hw/rtl/sgcp_in_reg.sv
hw/rtl/sgcp_parse_core.sv
hw/rtl/sgcp_out_reg.sv
hw/rtl/set_get_command_stream_parser.sv
test/sgcp_event_check.sv
test/tb.sv
